// ===== hdl/headset_jack_type_detector_defines.svh =====
// Assertion macros shared by the headset jack type detector
`ifndef HEADSET_JACK_TYPE_DETECTOR_DEFINES_SVH
`define HEADSET_JACK_TYPE_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define HJTD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define HJTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hjtd_pkg.sv =====
package hjtd_pkg;

    // Timing and threshold constants
    localparam int DETECT_STABLE_SAMPLES = 20;
    localparam int ABNORMAL_LIMIT        = 100;
    localparam int LOW_ADC_RETRIES       = 10;
    localparam int KEY_STABLE_SAMPLES    = 6;
    localparam int KEY_BLOCK_TICKS       = 200;

    localparam int ADC_W      = 13;
    localparam int STABLE_W   = 5;
    localparam int ABNORMAL_W = 7;
    localparam int LOW_W      = 4;
    localparam int BLOCK_W    = 8;
    localparam int DEBOUNCE_W = 3;
    localparam int CFG_IDX_W  = 3;

    localparam logic [ADC_W-1:0] ADC_HIGH_ABNORMAL = 13'd3250;
    localparam logic [ADC_W-1:0] ADC_MID_ABNORMAL  = 13'd600;
    localparam logic [ADC_W-1:0] ADC_LOW_RESET     = 13'd500;
    localparam logic [ADC_W-1:0] ADC_HIGH_RESET    = 13'd3300;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_STABLE   = 2'd1,
        PH_CLASSIFY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        DEV_NONE  = 2'd0,
        DEV_3POLE = 2'd1,
        DEV_4POLE = 2'd2
    } t_dev;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADC_LOW    = 3'd0,
        CFG_ADC_HIGH   = 3'd1,
        CFG_DET_INV    = 3'd2,
        CFG_KEY_INV    = 3'd3,
        CFG_DUAL_KEY   = 3'd4
    } t_cfg_idx;

    // Settings used by the jack classifier
    typedef struct packed {
        logic [ADC_W-1:0] adc_low;
        logic [ADC_W-1:0] adc_high;
    } t_jack_cfg;

    // Per-tick jack status handed to the key debouncer and the output stage
    typedef struct packed {
        logic det;
        logic det_chg;
        t_dev dev;
        logic bias;
        logic type_chg;
    } t_jack_evt;

endpackage

// ===== hdl/headset_jack_type_detector.sv =====
// Headset jack type detector with send/end key debounce.
// Input stream: one request per sample tick carrying the detect pin, both
// key pins, a 13-bit mic ADC sample and the recording flag. Output stream:
// one result per request with the jack type, mic bias enable, the reported
// key level and the key/type change flags.
// Latency: the result of a request is valid the cycle after it is accepted.
// Throughput: one request per clock; the jack and key state update in the
// same cycle the request is taken, and one output register holds the result.
// When the receiver stalls, the output register holds its result and the
// input is taken again in the cycle the result leaves.
// Configuration: thresholds and pin polarity (i_cfg_* port) take effect next
// tick; the user must write them with no request in flight (block does not check).
// Reset (synchronous, active low): no device, bias off, key released,
// the key blocked until the block window after the first detect change
// ends, registers to defaults.
`include "headset_jack_type_detector_defines.svh"

module headset_jack_type_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hjtd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hjtd_pkg::ADC_W-1:0]        i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // detect_pin, key_pin_a, key_pin_b, mic_adc[12:0], recording, 7 zero bits
    input  logic [23:0]                       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // jack_type[1:0], mic_bias_on, key_down, key_changed, type_changed, 2 zero bits
    output logic [7:0]                        m_axis_tdata
);

    logic [hjtd_pkg::ADC_W-1:0] r_adc_low;
    logic [hjtd_pkg::ADC_W-1:0] r_adc_high;
    logic                       r_det_inv;
    logic                       r_key_inv;
    logic                       r_dual_key;

    logic                       r_out_valid;
    logic [7:0]                 r_out_data;

    hjtd_pkg::t_jack_cfg        jack_cfg;
    hjtd_pkg::t_jack_evt        evt;
    logic                       accept;
    logic                       det;
    logic                       key;
    logic                       key_down;
    logic                       key_chg;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_low  <= hjtd_pkg::ADC_LOW_RESET;
            r_adc_high <= hjtd_pkg::ADC_HIGH_RESET;
            r_det_inv  <= 1'b0;
            r_key_inv  <= 1'b0;
            r_dual_key <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hjtd_pkg::CFG_ADC_LOW:  r_adc_low  <= i_cfg_data;
                hjtd_pkg::CFG_ADC_HIGH: r_adc_high <= i_cfg_data;
                hjtd_pkg::CFG_DET_INV:  r_det_inv  <= i_cfg_data[0];
                hjtd_pkg::CFG_KEY_INV:  r_key_inv  <= i_cfg_data[0];
                hjtd_pkg::CFG_DUAL_KEY: r_dual_key <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Take a request whenever the output register is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Apply pin polarity and key pin selection
    assign det = s_axis_tdata[0] ^ r_det_inv;
    assign key = (s_axis_tdata[1] ^ r_key_inv) |
                 (r_dual_key & (s_axis_tdata[2] ^ r_key_inv));

    assign jack_cfg.adc_low  = r_adc_low;
    assign jack_cfg.adc_high = r_adc_high;

    hjtd_jack u_jack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_det   (det),
        .i_adc   (s_axis_tdata[15:3]),
        .i_rec   (s_axis_tdata[16]),
        .i_cfg   (jack_cfg),
        .o_evt   (evt)
    );

    hjtd_key u_key (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (accept),
        .i_key      (key),
        .i_evt      (evt),
        .o_key_down (key_down),
        .o_key_chg  (key_chg)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {2'b00, evt.type_chg, key_chg, key_down, evt.bias, evt.dev};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A key press (key_down with key_changed) is only reported with a 4-pole headset present
    `HJTD_ASSERT_IMPL(a_key_press_4pole, i_clk, i_rst_n,
        r_out_valid && r_out_data[3] && r_out_data[4],
        r_out_data[1:0] == hjtd_pkg::DEV_4POLE, "key press reported without 4-pole")
    // A 4-pole decision always comes with the mic bias on
    `HJTD_ASSERT_IMPL(a_4pole_bias, i_clk, i_rst_n,
        r_out_valid && r_out_data[5] && (r_out_data[1:0] == hjtd_pkg::DEV_4POLE),
        r_out_data[2], "4-pole reported with bias off")
    // An accepted request always leaves a result in the output register
    `HJTD_ASSERT_NEXT(a_accept_result, i_clk, i_rst_n, accept, r_out_valid,
        "accepted request produced no result")

endmodule

// ===== hdl/hjtd_jack.sv =====
module hjtd_jack (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_det,
    input  logic [hjtd_pkg::ADC_W-1:0] i_adc,
    input  logic                     i_rec,
    input  hjtd_pkg::t_jack_cfg      i_cfg,
    output hjtd_pkg::t_jack_evt      o_evt
);

    hjtd_pkg::t_phase                   r_phase, n_phase;
    logic [hjtd_pkg::STABLE_W-1:0]      r_stable, n_stable;
    logic [hjtd_pkg::ABNORMAL_W-1:0]    r_abn, n_abn;
    logic [hjtd_pkg::LOW_W-1:0]         r_low, n_low;
    hjtd_pkg::t_dev                     r_dev, n_dev;
    logic                               r_bias, n_bias;
    logic                               r_prev_det;

    logic in_window;
    logic abnormal;
    logic det_chg;
    logic type_chg;

    assign det_chg   = i_det != r_prev_det;
    assign in_window = (i_adc > i_cfg.adc_low) && (i_adc <= i_cfg.adc_high);
    assign abnormal  = (i_adc > hjtd_pkg::ADC_HIGH_ABNORMAL) ||
                       (!in_window && (i_adc > hjtd_pkg::ADC_MID_ABNORMAL));

    // Next jack state: insertion, removal, stability count and classification
    always_comb begin
        n_phase  = r_phase;
        n_stable = r_stable;
        n_abn    = r_abn;
        n_low    = r_low;
        n_dev    = r_dev;
        n_bias   = r_bias;
        type_chg = 1'b0;
        if (det_chg) begin
            if (i_det) begin
                n_bias   = 1'b1;
                n_phase  = hjtd_pkg::PH_STABLE;
                n_stable = '0;
            end else begin
                n_phase = hjtd_pkg::PH_IDLE;
                if (r_dev != hjtd_pkg::DEV_NONE) begin
                    n_dev    = hjtd_pkg::DEV_NONE;
                    type_chg = 1'b1;
                    if (!i_rec) begin
                        n_bias = 1'b0;
                    end
                end
            end
        end else begin
            unique case (r_phase)
                hjtd_pkg::PH_STABLE: begin
                    n_stable = r_stable + 1'b1;
                    if (n_stable >= hjtd_pkg::STABLE_W'(hjtd_pkg::DETECT_STABLE_SAMPLES)) begin
                        n_phase = hjtd_pkg::PH_CLASSIFY;
                        n_abn   = '0;
                        n_low   = '0;
                    end
                end
                hjtd_pkg::PH_CLASSIFY: begin
                    if (abnormal) begin
                        if (r_abn > hjtd_pkg::ABNORMAL_W'(hjtd_pkg::ABNORMAL_LIMIT)) begin
                            type_chg = 1'b1;
                            n_dev    = hjtd_pkg::DEV_3POLE;
                        end else begin
                            n_abn = r_abn + 1'b1;
                        end
                    end else if (in_window) begin
                        type_chg = 1'b1;
                        n_dev    = hjtd_pkg::DEV_4POLE;
                        n_bias   = 1'b1;
                        n_phase  = hjtd_pkg::PH_IDLE;
                    end else if ((i_adc == '0) ||
                                 (r_low == hjtd_pkg::LOW_W'(hjtd_pkg::LOW_ADC_RETRIES))) begin
                        type_chg = 1'b1;
                        n_dev    = hjtd_pkg::DEV_3POLE;
                    end else begin
                        n_low = r_low + 1'b1;
                    end
                    // Settle as 3-pole
                    if (type_chg && (n_dev == hjtd_pkg::DEV_3POLE)) begin
                        n_abn   = '0;
                        n_low   = '0;
                        n_phase = hjtd_pkg::PH_IDLE;
                        if (!i_rec) begin
                            n_bias = 1'b0;
                        end
                    end
                end
                default: begin
                    n_phase = hjtd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Advance state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= hjtd_pkg::PH_IDLE;
            r_stable   <= '0;
            r_abn      <= '0;
            r_low      <= '0;
            r_dev      <= hjtd_pkg::DEV_NONE;
            r_bias     <= 1'b0;
            r_prev_det <= 1'b0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_stable   <= n_stable;
            r_abn      <= n_abn;
            r_low      <= n_low;
            r_dev      <= n_dev;
            r_bias     <= n_bias;
            r_prev_det <= i_det;
        end
    end

    assign o_evt.det      = i_det;
    assign o_evt.det_chg  = det_chg;
    assign o_evt.dev      = n_dev;
    assign o_evt.bias     = n_bias;
    assign o_evt.type_chg = type_chg;

endmodule

// ===== hdl/hjtd_key.sv =====
module hjtd_key (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_key,
    input  hjtd_pkg::t_jack_evt i_evt,
    output logic                o_key_down,
    output logic                o_key_chg
);

    logic [hjtd_pkg::BLOCK_W-1:0]    r_timer, n_timer;
    logic                            r_allowed, n_allowed;
    logic [hjtd_pkg::DEBOUNCE_W-1:0] r_dbc, n_dbc;
    logic                            r_cand, n_cand;
    logic                            r_rep, n_rep;
    logic                            r_prev_key;
    logic                            chg;
    logic                            rep_mid;

    // Block timer, debounce counter and reported key level
    always_comb begin
        n_timer   = r_timer;
        n_allowed = r_allowed;
        n_dbc     = r_dbc;
        n_cand    = r_cand;
        chg       = 1'b0;
        rep_mid   = r_rep;
        if (i_evt.det_chg) begin
            n_allowed = 1'b0;
            n_timer   = hjtd_pkg::BLOCK_W'(hjtd_pkg::KEY_BLOCK_TICKS);
        end
        // Release the key when the block window ends with the jack out
        if (n_timer != '0) begin
            n_timer = n_timer - 1'b1;
            if (n_timer == '0) begin
                n_allowed = 1'b1;
                if (rep_mid && !i_evt.det) begin
                    rep_mid = 1'b0;
                    chg     = 1'b1;
                end
            end
        end
        n_rep = rep_mid;
        if ((i_key != r_prev_key) && n_allowed && i_evt.det &&
            (i_evt.dev == hjtd_pkg::DEV_4POLE)) begin
            if (rep_mid) begin
                n_dbc = '0;
                n_rep = i_key;
                chg   = 1'b1;
            end else begin
                n_cand = i_key;
                n_dbc  = hjtd_pkg::DEBOUNCE_W'(hjtd_pkg::KEY_STABLE_SAMPLES);
            end
        end else if (r_dbc != '0) begin
            if ((i_key != r_cand) || !i_evt.det || (i_evt.dev == hjtd_pkg::DEV_3POLE)) begin
                n_dbc = '0;
            end else begin
                n_dbc = r_dbc - 1'b1;
                if (n_dbc == '0) begin
                    n_rep = r_cand;
                    chg   = 1'b1;
                end
            end
        end
    end

    // Advance state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer    <= '0;
            r_allowed  <= 1'b0;
            r_dbc      <= '0;
            r_cand     <= 1'b0;
            r_rep      <= 1'b0;
            r_prev_key <= 1'b0;
        end else if (i_en) begin
            r_timer    <= n_timer;
            r_allowed  <= n_allowed;
            r_dbc      <= n_dbc;
            r_cand     <= n_cand;
            r_rep      <= n_rep;
            r_prev_key <= i_key;
        end
    end

    assign o_key_down = n_rep;
    assign o_key_chg  = chg;

endmodule

// ===== test/jack_result_checker.sv =====
// Watches the request and result streams of the jack detector, tracks the
// jack/key state per accepted request and compares every accepted result.
module jack_result_checker
    import hjtd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADC_W-1:0]     i_cfg_data,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    // detect_pin, key_pin_a, key_pin_b, mic_adc[12:0], recording, 7 zero bits
    input  logic [23:0]          i_req_data,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    // jack_type[1:0], mic_bias_on, key_down, key_changed, type_changed, 2 zero bits
    input  logic [7:0]           i_res_data,
    output int                   o_mismatches,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Result fields, lowest bit last so the layout matches the result stream
    typedef struct packed {
        logic type_chg;
        logic key_chg;
        logic key_down;
        logic bias;
        t_dev jack;
    } t_jack_res;

    t_jack_res expected_q[$];
    int        mismatch_total = 0;
    int        result_cnt = 0;

    // Register copies
    logic [ADC_W-1:0] win_low, win_high;
    logic             det_inv, key_inv, dual_keys;

    // Jack and key state
    t_phase                jack_phase;
    logic [STABLE_W-1:0]   stable_ticks;
    logic [ABNORMAL_W-1:0] abnormal_seen;
    logic [LOW_W-1:0]      low_seen;
    t_dev                  dev_now;
    logic [BLOCK_W-1:0]    key_block;
    logic                  key_open;
    logic [DEBOUNCE_W-1:0] debounce_left;
    logic                  key_cand, key_held, last_det, last_key, bias;

    assign o_mismatches = mismatch_total;

    // Settle on a 3-pole device and leave classification
    task automatic settle_three_pole(input logic rec);
        dev_now       = DEV_3POLE;
        abnormal_seen = '0;
        low_seen      = '0;
        jack_phase    = PH_IDLE;
        if (!rec) begin
            bias = 1'b0;
        end
    endtask

    // Advance the jack and key state by one sample tick
    task automatic predict_tick(input logic [23:0] req, output t_jack_res res);
        logic             det, ka, kb, key, rec, in_win;
        logic [ADC_W-1:0] adc;
        det = req[0] ^ det_inv;
        ka  = req[1] ^ key_inv;
        kb  = req[2] ^ key_inv;
        adc = req[15:3];
        rec = req[16];
        key = ka | (dual_keys & kb);
        res = '0;

        // Detect edge, stability count, classification
        if (det != last_det) begin
            key_open  = 1'b0;
            key_block = BLOCK_W'(KEY_BLOCK_TICKS);
            if (det) begin
                bias         = 1'b1;
                jack_phase   = PH_STABLE;
                stable_ticks = '0;
            end else begin
                jack_phase = PH_IDLE;
                if (dev_now != DEV_NONE) begin
                    dev_now      = DEV_NONE;
                    res.type_chg = 1'b1;
                    if (!rec) begin
                        bias = 1'b0;
                    end
                end
            end
        end else if (jack_phase == PH_STABLE) begin
            stable_ticks = stable_ticks + 1'b1;
            if (stable_ticks >= DETECT_STABLE_SAMPLES) begin
                jack_phase    = PH_CLASSIFY;
                abnormal_seen = '0;
                low_seen      = '0;
            end
        end else if (jack_phase == PH_CLASSIFY) begin
            in_win = (adc > win_low) && (adc <= win_high);
            if (adc > ADC_HIGH_ABNORMAL || (!in_win && adc > ADC_MID_ABNORMAL)) begin
                if (abnormal_seen > ABNORMAL_LIMIT) begin
                    settle_three_pole(rec);
                    res.type_chg = 1'b1;
                end else begin
                    abnormal_seen = abnormal_seen + 1'b1;
                end
            end else if (in_win) begin
                dev_now      = DEV_4POLE;
                bias         = 1'b1;
                jack_phase   = PH_IDLE;
                res.type_chg = 1'b1;
            end else if (adc == '0 || low_seen == LOW_ADC_RETRIES) begin
                settle_three_pole(rec);
                res.type_chg = 1'b1;
            end else begin
                low_seen = low_seen + 1'b1;
            end
        end else begin
            jack_phase = PH_IDLE;
        end

        // Key block window; release a held key once the jack is gone
        if (key_block != '0) begin
            key_block = key_block - 1'b1;
            if (key_block == '0) begin
                key_open = 1'b1;
                if (key_held && !det) begin
                    key_held    = 1'b0;
                    res.key_chg = 1'b1;
                end
            end
        end

        // Key debounce
        if (key != last_key && key_open && det && dev_now == DEV_4POLE) begin
            if (key_held) begin
                debounce_left = '0;
                key_held      = key;
                res.key_chg   = 1'b1;
            end else begin
                key_cand      = key;
                debounce_left = DEBOUNCE_W'(KEY_STABLE_SAMPLES);
            end
        end else if (debounce_left != '0) begin
            if (key != key_cand || !det || dev_now == DEV_3POLE) begin
                debounce_left = '0;
            end else begin
                debounce_left = debounce_left - 1'b1;
                if (debounce_left == '0) begin
                    key_held    = key_cand;
                    res.key_chg = 1'b1;
                end
            end
        end

        last_det     = det;
        last_key     = key;
        res.jack     = dev_now;
        res.bias     = bias;
        res.key_down = key_held;
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            if (mismatch_total < 10) begin
                $display("result %0d: %s expected %0d, got %0d", result_cnt, what, want, got);
            end
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_jack_res want, got;
        if (!i_rst_n) begin
            expected_q.delete();
            win_low       = ADC_LOW_RESET;
            win_high      = ADC_HIGH_RESET;
            det_inv       = 1'b0;
            key_inv       = 1'b0;
            dual_keys     = 1'b1;
            jack_phase    = PH_IDLE;
            stable_ticks  = '0;
            abnormal_seen = '0;
            low_seen      = '0;
            dev_now       = DEV_NONE;
            key_block     = '0;
            key_open      = 1'b0;
            debounce_left = '0;
            key_cand      = 1'b0;
            key_held      = 1'b0;
            last_det      = 1'b0;
            last_key      = 1'b0;
            bias          = 1'b0;
            o_pending    <= 0;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ADC_LOW:  win_low   = i_cfg_data;
                    CFG_ADC_HIGH: win_high  = i_cfg_data;
                    CFG_DET_INV:  det_inv   = i_cfg_data[0];
                    CFG_KEY_INV:  key_inv   = i_cfg_data[0];
                    CFG_DUAL_KEY: dual_keys = i_cfg_data[0];
                    default: ;
                endcase
            end

            // Compare an accepted result with the oldest expectation
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    if (mismatch_total < 10) begin
                        $display("result %0d: unexpected, got %h", result_cnt, i_res_data);
                    end
                    mismatch_total++;
                end else begin
                    want = expected_q.pop_front();
                    got  = t_jack_res'(i_res_data[5:0]);
                    check_field("jack_type", int'(want.jack), int'(got.jack));
                    check_field("mic_bias_on", int'(want.bias), int'(got.bias));
                    check_field("key_down", int'(want.key_down), int'(got.key_down));
                    check_field("key_changed", int'(want.key_chg), int'(got.key_chg));
                    check_field("type_changed", int'(want.type_chg), int'(got.type_chg));
                end
                result_cnt++;
            end

            // Predict the result of an accepted request
            if (i_req_valid && i_req_ready) begin
                predict_tick(i_req_data, want);
                expected_q.push_back(want);
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

// ===== test/tb_headset_jack_type_detector.sv =====
module tb_headset_jack_type_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import hjtd_pkg::*;

    localparam int ITEMS_PER_SETTING = 190;
    localparam int SETTING_COUNT     = 5;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT       = 800000;

    typedef enum logic [1:0] {
        SMP_ZERO,
        SMP_LOW,
        SMP_WIN,
        SMP_ABN
    } t_sample_kind;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [ADC_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;

    int          pending;
    int          mismatches;
    int          sent = 0;
    int unsigned cycle_cnt = 0;
    logic        quiet = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;

    // Register values as last written
    logic [ADC_W-1:0] win_low = ADC_LOW_RESET;
    logic [ADC_W-1:0] win_high = ADC_HIGH_RESET;
    logic             det_inv = 1'b0;
    logic             key_inv = 1'b0;
    logic             dual_keys = 1'b1;

    logic [ADC_W-1:0] adc_edges [16] = '{
        13'd0, 13'd1, 13'd500, 13'd501, 13'd600, 13'd601, 13'd3250, 13'd3251,
        13'd3300, 13'd3301, 13'd2730, 13'd4096, 13'd5461, 13'd8190, 13'd8191, 13'd4095
    };

    headset_jack_type_detector u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    jack_result_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req_valid  (s_tvalid),
        .i_req_ready  (s_tready),
        .i_req_data   (s_tdata),
        .i_res_valid  (m_tvalid),
        .i_res_ready  (m_tready),
        .i_res_data   (m_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_headset_jack_type_detector NOT OK");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off on request
    initial begin : receiver
        wait (rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                hold_done = 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    function automatic logic [23:0] pack_req(input logic det, input logic ka, input logic kb,
                                             input logic [ADC_W-1:0] adc, input logic rec);
        return {7'd0, rec, adc, kb, ka, det};
    endfunction

    // How the classifier will treat an ADC sample under the current window
    function automatic t_sample_kind sample_kind(input logic [ADC_W-1:0] adc);
        logic in_win;
        in_win = (adc > win_low) && (adc <= win_high);
        if (adc > ADC_HIGH_ABNORMAL || (!in_win && adc > ADC_MID_ABNORMAL)) begin
            return SMP_ABN;
        end else if (in_win) begin
            return SMP_WIN;
        end else if (adc == '0) begin
            return SMP_ZERO;
        end
        return SMP_LOW;
    endfunction

    // Draw a sample of the wanted kind, often a boundary value
    function automatic logic [ADC_W-1:0] pick_adc(input t_sample_kind kind);
        logic [ADC_W-1:0] v;
        v = '0;
        for (int n = 0; n < 64; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 9))
                    0: v = 13'd0;
                    1: v = 13'd1;
                    2: v = ADC_MID_ABNORMAL;
                    3: v = ADC_MID_ABNORMAL + 13'd1;
                    4: v = ADC_HIGH_ABNORMAL;
                    5: v = ADC_HIGH_ABNORMAL + 13'd1;
                    6: v = 13'd8191;
                    7: v = win_low;
                    8: v = win_low + 13'd1;
                    default: v = win_high;
                endcase
            end else begin
                case (kind)
                    SMP_ZERO: v = '0;
                    SMP_LOW:  v = 13'($urandom_range(1, 600));
                    SMP_WIN:  v = (win_low < win_high) ?
                                  13'($urandom_range(int'(win_low) + 1, int'(win_high))) :
                                  13'($urandom);
                    default:  v = 13'($urandom_range(601, 8191));
                endcase
            end
            if (sample_kind(v) == kind) begin
                return v;
            end
        end
        return v;
    endfunction

    // Offer one request and wait until it is taken
    task automatic send_req(input logic [23:0] d);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    // Send one tick given logical detect and key levels
    task automatic send_tick(input logic det, input logic key_lvl, input logic [ADC_W-1:0] adc);
        logic ka, kb, rec;
        if (key_lvl) begin
            if (dual_keys) begin
                case ($urandom_range(0, 2))
                    0:       begin ka = 1'b1; kb = 1'b0; end
                    1:       begin ka = 1'b0; kb = 1'b1; end
                    default: begin ka = 1'b1; kb = 1'b1; end
                endcase
            end else begin
                ka = 1'b1;
                kb = 1'($urandom_range(0, 1));
            end
        end else begin
            ka = 1'b0;
            kb = dual_keys ? 1'b0 : 1'($urandom_range(0, 1));
        end
        rec = ($urandom_range(0, 3) == 0);
        send_req(pack_req(det ^ det_inv, ka ^ key_inv, kb ^ key_inv, adc, rec));
    endtask

    // Write all registers once the block has drained
    task automatic apply_settings(input logic [ADC_W-1:0] lo, input logic [ADC_W-1:0] hi,
                                  input logic dinv, input logic kinv, input logic dual);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ADC_LOW;
        cfg_data <= lo;
        @(posedge clk);
        cfg_idx  <= CFG_ADC_HIGH;
        cfg_data <= hi;
        @(posedge clk);
        cfg_idx  <= CFG_DET_INV;
        cfg_data <= {12'd0, dinv};
        @(posedge clk);
        cfg_idx  <= CFG_KEY_INV;
        cfg_data <= {12'd0, kinv};
        @(posedge clk);
        cfg_idx  <= CFG_DUAL_KEY;
        cfg_data <= {12'd0, dual};
        @(posedge clk);
        cfg_we <= 1'b0;
        win_low   = lo;
        win_high  = hi;
        det_inv   = dinv;
        key_inv   = kinv;
        dual_keys = dual;
    endtask

    // One plug cycle: out, insert, classify, key activity, removal; or out, then pure noise
    task automatic plug_cycle();
        int   scen, remaining, hold;
        logic key_lvl;
        key_lvl = 1'b0;
        repeat ($urandom_range(1, 6)) send_tick(1'b0, 1'($urandom_range(0, 1)), 13'($urandom));
        scen = $urandom_range(0, 9);

        // Pure noise on every pin
        if (scen == 0) begin
            repeat ($urandom_range(10, 40)) begin
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 13'($urandom));
            end
            return;
        end

        // Bouncing contact, then a clean insertion and stability wait
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 19)) send_tick(1'b1, 1'($urandom_range(0, 1)), 13'($urandom));
            repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)), 13'($urandom));
        end
        repeat (DETECT_STABLE_SAMPLES + 1) begin
            send_tick(1'b1, 1'($urandom_range(0, 1)), 13'($urandom));
        end

        // Classification
        case (scen)
            1, 2, 3, 4: begin
                repeat ($urandom_range(0, 4)) begin
                    send_tick(1'b1, 1'b0, pick_adc($urandom_range(0, 1) ? SMP_LOW : SMP_ABN));
                end
                send_tick(1'b1, 1'b0, pick_adc(SMP_WIN));
            end
            5: begin
                repeat ($urandom_range(0, 9)) send_tick(1'b1, 1'b0, pick_adc(SMP_LOW));
                send_tick(1'b1, 1'b0, 13'd0);
            end
            6: begin
                repeat (LOW_ADC_RETRIES + $urandom_range(0, 1)) begin
                    send_tick(1'b1, 1'b0, pick_adc(SMP_LOW));
                end
            end
            7: begin
                repeat (ABNORMAL_LIMIT + 2) send_tick(1'b1, 1'b0, pick_adc(SMP_ABN));
            end
            default: begin
                repeat ($urandom_range(1, 30)) send_tick(1'b1, 1'b0, 13'($urandom));
            end
        endcase

        // Key activity while plugged; long stays outlast the key block window
        remaining = ($urandom_range(0, 1) == 0) ? $urandom_range(200, 320) : $urandom_range(5, 40);
        while (remaining > 0) begin
            hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, KEY_STABLE_SAMPLES)
                                               : $urandom_range(KEY_STABLE_SAMPLES + 1, 16);
            key_lvl = ~key_lvl;
            repeat (hold) begin
                send_tick(1'b1, key_lvl, 13'($urandom));
                remaining--;
            end
        end

        // Removal; a long one lets the block window close with the jack out
        if ($urandom_range(0, 3) == 0) begin
            repeat (KEY_BLOCK_TICKS + $urandom_range(1, 10)) begin
                send_tick(1'b0, 1'($urandom_range(0, 1)), 13'($urandom));
            end
        end else begin
            repeat ($urandom_range(1, 10)) send_tick(1'b0, key_lvl, 13'($urandom));
        end
    endtask

    initial begin : stimulus
        int target;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int setting = 0; setting < SETTING_COUNT; setting++) begin
            case (setting)
                0: apply_settings(ADC_LOW_RESET, ADC_HIGH_RESET, 1'b0, 1'b0, 1'b1);
                1: apply_settings(13'd0, 13'd8191, 1'b1, 1'b1, 1'b0);
                2: apply_settings(13'd8191, 13'd0, 1'b0, 1'b1, 1'b1);
                3: apply_settings(13'($urandom_range(0, 3000)), 13'($urandom_range(600, 8191)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                default: apply_settings(ADC_MID_ABNORMAL, ADC_HIGH_ABNORMAL, 1'b1, 1'b0, 1'b1);
            endcase

            // Walk every pin bit both ways with ADC boundary values
            if (setting == 0) begin
                for (int i = 0; i < 16; i++) begin
                    send_req(pack_req(i[0], i[1], i[2], adc_edges[i], i[3]));
                end
            end
            if (setting == 1) begin
                hold_req = 1'b1;
            end
            if (setting == SETTING_COUNT - 1) begin
                quiet = 1'b1;
            end

            target = sent + ITEMS_PER_SETTING;
            while (sent < target) plug_cycle();
        end

        // Drain and settle
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0 && pending == 0) begin
            $display("tb_headset_jack_type_detector OK");
        end else begin
            $display("tb_headset_jack_type_detector NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/hjtd_pkg.sv
hdl/hjtd_jack.sv
hdl/hjtd_key.sv
hdl/headset_jack_type_detector.sv
test/jack_result_checker.sv
test/tb_headset_jack_type_detector.sv
